>>> rtl/core/rps_pkg.sv
// Package: shared types and constants for the register pool splitter.
package rps_pkg;

    localparam int FIELD_W       = 32;
    localparam int COUNT_W       = 8;
    localparam int MASK_BITS_DEF = 32;

    typedef struct packed {
        logic [FIELD_W-1:0] avail_preserved;
        logic [FIELD_W-1:0] avail_scratch;
        logic [FIELD_W-1:0] prealloc_mask;
        logic [COUNT_W-1:0] need_global_preserved;
        logic [COUNT_W-1:0] need_global_scratch;
        logic [COUNT_W-1:0] need_local_preserved;
        logic [COUNT_W-1:0] need_local_scratch;
    } rps_req_t;

    typedef struct packed {
        logic [FIELD_W-1:0] pool_global_preserved;
        logic [FIELD_W-1:0] pool_global_scratch;
    } rps_rsp_t;

    // Decisions made after the counting pass, consumed by the grant pass.
    typedef struct packed {
        logic [COUNT_W-1:0] need_gp;     // global preserved demand
        logic [COUNT_W-1:0] need_lp;     // local preserved demand
        logic [COUNT_W:0]   need_ls_sp;  // local scratch demand plus spill register
        logic               pres_ok;     // preserved supply above global demand
        logic               scr_ok;      // scratch supply above local demand + spill
        logic               loc_ok;      // leftover preserved beyond local demand
    } rps_plan_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUNT,
        ST_PLAN,
        ST_GRANT,
        ST_DONE
    } rps_state_t;

endpackage

>>> rtl/core/register_pool_splitter_core.sv
// Top level of the register pool splitter: control, mask shifters, planning.
//
// A transaction is accepted when start is high and busy is low. The block then
// makes two bit-serial passes over the low min(MASK_BITS, 32) mask bits, one
// bit per clock: a counting pass that finds the preserved and scratch supply,
// a planning state that works out the spill flag and the pool conditions,
// and a grant pass that picks the lowest registers with running prefix counts.
// Done is high for exactly one cycle, in ST_DONE, which follows ST_COUNT,
// ST_PLAN and ST_GRANT in that order; result is valid then and holds until the
// next grant pass. Busy stays high outside ST_IDLE, so a new transaction is
// taken only after the last one is done. The receiver cannot stall: done is a
// one-cycle strobe and result must be captured on that edge. Mask bits at or
// above MASK_BITS are ignored and read back as zero.
module register_pool_splitter_core
    import rps_pkg::*;
#(
    parameter int MASK_BITS = MASK_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  rps_req_t request,
    output logic     done,
    output rps_rsp_t result
);

    // bits above the field width are always zero, so the scan stops there
    localparam int SCAN  = (MASK_BITS < FIELD_W) ? MASK_BITS : FIELD_W;
    localparam int CNT_W = $clog2(SCAN + 1);
    localparam int IDX_W = $clog2(SCAN);

    rps_state_t state_reg, state_next;
    logic [IDX_W-1:0] bit_cnt_reg, bit_cnt_next;

    // mask shifters rotate so the counting pass leaves them intact for granting
    logic [SCAN-1:0] pres_reg, scr_reg, pre_reg;
    logic [COUNT_W-1:0] gp_reg, gs_reg, lp_reg, ls_reg;
    rps_plan_t plan_reg, plan_next;

    logic accept, shift_en, cnt_en, grant_en, last_bit;
    logic [CNT_W-1:0] n_p, n_s;

    // planning arithmetic, all narrow
    logic [COUNT_W+1:0] sum_p, sum_all, supply_p, supply_all;
    logic               spill;

    assign accept   = start && !busy;
    assign last_bit = (bit_cnt_reg == IDX_W'(SCAN - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        busy         = 1'b1;
        done         = 1'b0;
        cnt_en       = 1'b0;
        grant_en     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy         = 1'b0;
                bit_cnt_next = '0;
                if (start)
                begin
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                cnt_en       = 1'b1;
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (last_bit)
                begin
                    bit_cnt_next = '0;
                    state_next   = ST_PLAN;
                end
            end
            ST_PLAN:
            begin
                state_next = ST_GRANT;
            end
            ST_GRANT:
            begin
                grant_en     = 1'b1;
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (last_bit)
                begin
                    bit_cnt_next = '0;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign shift_en = cnt_en || grant_en;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pres_reg <= request.avail_preserved[SCAN-1:0];
            scr_reg  <= request.avail_scratch[SCAN-1:0];
            pre_reg  <= request.prealloc_mask[SCAN-1:0];
            gp_reg   <= request.need_global_preserved;
            gs_reg   <= request.need_global_scratch;
            lp_reg   <= request.need_local_preserved;
            ls_reg   <= request.need_local_scratch;
        end
        else if (shift_en)
        begin
            pres_reg <= {pres_reg[0], pres_reg[SCAN-1:1]};
            scr_reg  <= {scr_reg[0], scr_reg[SCAN-1:1]};
            pre_reg  <= {pre_reg[0], pre_reg[SCAN-1:1]};
        end
    end

    rps_popcount #(
        .SCAN_BITS (SCAN)
    ) u_popcount (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (accept),
        .en    (cnt_en),
        .bit_p (pres_reg[0]),
        .bit_s (scr_reg[0]),
        .n_p   (n_p),
        .n_s   (n_s)
    );

    // spill when preserved demand beats preserved supply, or total beats total
    always_comb
    begin
        supply_p   = (COUNT_W+2)'(n_p);
        supply_all = (COUNT_W+2)'(n_p) + (COUNT_W+2)'(n_s);
        sum_p      = (COUNT_W+2)'(gp_reg) + (COUNT_W+2)'(lp_reg);
        sum_all    = sum_p + (COUNT_W+2)'(gs_reg) + (COUNT_W+2)'(ls_reg);
        spill      = (sum_p > supply_p) || (sum_all > supply_all);

        plan_next            = plan_reg;
        plan_next.need_gp    = gp_reg;
        plan_next.need_lp    = lp_reg;
        plan_next.need_ls_sp = (COUNT_W+1)'(ls_reg) + (COUNT_W+1)'(spill);
        plan_next.pres_ok    = supply_p > (COUNT_W+2)'(gp_reg);
        plan_next.scr_ok     = (COUNT_W+1)'(n_s) > plan_next.need_ls_sp;
        // leftover local preserved: n_p - g_p > l_p, i.e. n_p > g_p + l_p
        plan_next.loc_ok     = supply_p > sum_p;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PLAN)
        begin
            plan_reg <= plan_next;
        end
    end

    logic [SCAN-1:0] glob_p, glob_s;

    rps_grant #(
        .SCAN_BITS (SCAN)
    ) u_grant (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (accept),
        .en      (grant_en),
        .bit_p   (pres_reg[0]),
        .bit_s   (scr_reg[0]),
        .bit_pre (pre_reg[0]),
        .plan    (plan_reg),
        .glob_p  (glob_p),
        .glob_s  (glob_s)
    );

    // grant shifters hold their value through the done cycle
    assign result.pool_global_preserved = FIELD_W'(glob_p);
    assign result.pool_global_scratch   = FIELD_W'(glob_s);

endmodule

>>> rtl/core/rps_popcount.sv
// Bit-serial population counter for the preserved and scratch masks.
module rps_popcount
    import rps_pkg::*;
#(
    parameter int SCAN_BITS = MASK_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           clear,
    input  logic                           en,
    input  logic                           bit_p,
    input  logic                           bit_s,
    output logic [$clog2(SCAN_BITS+1)-1:0] n_p,
    output logic [$clog2(SCAN_BITS+1)-1:0] n_s
);

    localparam int CNT_W = $clog2(SCAN_BITS + 1);

    logic [CNT_W-1:0] n_p_reg, n_p_next;
    logic [CNT_W-1:0] n_s_reg, n_s_next;

    always_comb
    begin
        n_p_next = n_p_reg;
        n_s_next = n_s_reg;
        if (clear)
        begin
            n_p_next = '0;
            n_s_next = '0;
        end
        else if (en)
        begin
            n_p_next = n_p_reg + CNT_W'(bit_p);
            n_s_next = n_s_reg + CNT_W'(bit_s);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_p_reg <= '0;
            n_s_reg <= '0;
        end
        else
        begin
            n_p_reg <= n_p_next;
            n_s_reg <= n_s_next;
        end
    end

    assign n_p = n_p_reg;
    assign n_s = n_s_reg;

endmodule

>>> rtl/core/rps_grant.sv
// Bit-serial grant pass: prefix counts pick the lowest registers per pool.
module rps_grant
    import rps_pkg::*;
#(
    parameter int SCAN_BITS = MASK_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear,
    input  logic                 en,
    input  logic                 bit_p,
    input  logic                 bit_s,
    input  logic                 bit_pre,
    input  rps_plan_t            plan,
    output logic [SCAN_BITS-1:0] glob_p,
    output logic [SCAN_BITS-1:0] glob_s
);

    localparam int CNT_W = $clog2(SCAN_BITS + 1);

    // prefix counts of preserved, scratch and local-preserved bits seen so far
    logic [CNT_W-1:0] cp_reg, cp_next;
    logic [CNT_W-1:0] cs_reg, cs_next;
    logic [CNT_W-1:0] cl_reg, cl_next;
    logic [SCAN_BITS-1:0] glob_p_reg, glob_s_reg;

    logic in_cov_p, in_cov_s, in_cov_l;
    logic gp_bit, lp_bit, gs_bit;

    always_comb
    begin
        in_cov_p = {{(COUNT_W + 1 - CNT_W){1'b0}}, cp_reg} < {1'b0, plan.need_gp};
        in_cov_s = {{(COUNT_W + 1 - CNT_W){1'b0}}, cs_reg} < plan.need_ls_sp;
        in_cov_l = {{(COUNT_W + 1 - CNT_W){1'b0}}, cl_reg} < {1'b0, plan.need_lp};
        gp_bit   = bit_p & (!plan.pres_ok | in_cov_p);
        lp_bit   = bit_p & plan.pres_ok & !in_cov_p;
        gs_bit   = (plan.scr_ok & bit_s & !in_cov_s & !bit_pre)
                 | (plan.loc_ok & lp_bit & !in_cov_l);

        cp_next = cp_reg;
        cs_next = cs_reg;
        cl_next = cl_reg;
        if (clear)
        begin
            cp_next = '0;
            cs_next = '0;
            cl_next = '0;
        end
        else if (en)
        begin
            cp_next = cp_reg + CNT_W'(bit_p);
            cs_next = cs_reg + CNT_W'(bit_s);
            cl_next = cl_reg + CNT_W'(lp_bit);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cp_reg <= '0;
            cs_reg <= '0;
            cl_reg <= '0;
        end
        else
        begin
            cp_reg <= cp_next;
            cs_reg <= cs_next;
            cl_reg <= cl_next;
        end
    end

    // result bits enter at the top and settle in place after a full scan
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            glob_p_reg <= {gp_bit, glob_p_reg[SCAN_BITS-1:1]};
            glob_s_reg <= {gs_bit, glob_s_reg[SCAN_BITS-1:1]};
        end
    end

    assign glob_p = glob_p_reg;
    assign glob_s = glob_s_reg;

endmodule

>>> rtl/core/rps_checker.sv
// Port-level checker for the register pool splitter, bound to the top level.
module rps_checker
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // an accepted transaction makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepted transaction");

    // done is a single-cycle strobe
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // result only comes while a transaction is in flight
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done raised while idle");

    // after the result the block is ready again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block still busy after result");

    // no result in the cycle right after acceptance
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result strobe too early");

endmodule

bind register_pool_splitter_core rps_checker u_rps_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
